// ----- sv/assert_macros.svh -----
// Assertion macros used by the result queue of the frame parser checksum check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define FPCC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FPCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FPCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FPCC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define FPCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define FPCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/fpcc_pkg.sv -----
// Shared types, constants and functions of the frame parser checksum check.
`timescale 1ns / 1ps

package fpcc_pkg;

	// Default width of the flags field in bytes.
	localparam int FLAG_BYTES_DEF = 1;

	// Saturation value of the byte counter.
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	// Checksum value of a good datagram.
	localparam logic [15:0] SUM_GOOD = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT_HDR = 3'd1,
		ST_SHORT_PAY = 3'd2,
		ST_SHORT_CK  = 3'd3,
		ST_MISMATCH  = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] seq_number;
		logic [7:0]  flag_bits;
		logic [15:0] payload_length;
		status_t     status;
		logic        final_res;
	} res_t;

	// Up to two results produced by one input byte, first in r0.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Ones-complement 16-bit add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
		logic [16:0] t;
		t = {1'b0, s} + {1'b0, w};
		return t[16] ? (t[15:0] + 16'd1) : t[15:0];
	endfunction

endpackage

// ----- sv/fpcc_byte_if.sv -----
// Byte request channel: one datagram byte with its end mark.
`timescale 1ns / 1ps

interface fpcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- sv/fpcc_res_if.sv -----
// Result request channel: payload byte or end-of-datagram status.
`timescale 1ns / 1ps

interface fpcc_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [15:0] seq_number;
	logic [7:0]  flag_bits;
	logic [15:0] payload_length;
	logic [2:0]  status;
	logic        final_res;

	modport source (output valid, output kind, output payload_byte, output seq_number,
		output flag_bits, output payload_length, output status, output final_res,
		input ready);
	modport sink (input valid, input kind, input payload_byte, input seq_number,
		input flag_bits, input payload_length, input status, input final_res,
		output ready);
endinterface

// ----- sv/fpcc_parser.sv -----
// Frame field parser, running checksum and status decision for one byte per cycle while take is high.
`timescale 1ns / 1ps

module fpcc_parser #(
	parameter int FLAG_BYTES = fpcc_pkg::FLAG_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                last,
	output fpcc_pkg::push_t     push
);

	localparam int HDR_BYTES = 4 + FLAG_BYTES;
	localparam logic [16:0] POS_FLAGS = 17'd2;
	localparam logic [16:0] POS_LEN_LO = 17'(2 + FLAG_BYTES);
	localparam logic [16:0] POS_LEN_HI = 17'(3 + FLAG_BYTES);
	localparam logic [17:0] LIM_HDR = 18'(HDR_BYTES);

	logic [16:0] count_q, count_n;
	logic        odd_q, odd_n;
	logic [15:0] seq_q, seq_n;
	logic [7:0]  flags_q, flags_n;
	logic [15:0] len_q, len_n;
	logic [15:0] sum_even_q, sum_even_n;
	logic [15:0] sum_odd_q, sum_odd_n;
	logic [7:0]  pend_q;

	logic [15:0] word;
	logic        is_payload;
	logic [17:0] total;
	logic [17:0] lim_pay;
	logic [17:0] lim_ck;
	logic [15:0] sum_sel;
	fpcc_pkg::status_t st;
	fpcc_pkg::res_t    pay_res;
	fpcc_pkg::res_t    st_res;

	// Header field capture and payload window.
	always_comb begin
		seq_n = seq_q;
		flags_n = flags_q;
		len_n = len_q;
		is_payload = 1'b0;
		if (count_q == 17'd0) begin
			seq_n[7:0] = data_byte;
		end else if (count_q == 17'd1) begin
			seq_n[15:8] = data_byte;
		end else if (count_q < POS_LEN_LO) begin
			if (count_q == POS_FLAGS) begin
				flags_n = data_byte;
			end
		end else if (count_q == POS_LEN_LO) begin
			len_n[7:0] = data_byte;
		end else if (count_q == POS_LEN_HI) begin
			len_n[15:8] = data_byte;
		end else begin
			is_payload = ({1'b0, count_q} < (LIM_HDR + {2'b00, len_q}));
		end
	end

	// Both pairings of the checksum run side by side; parity picks one at the end.
	always_comb begin
		word = {data_byte, pend_q};
		sum_even_n = sum_even_q;
		sum_odd_n = sum_odd_q;
		if (!odd_q) begin
			if (count_q == 17'd0) begin
				sum_odd_n = {8'h00, data_byte};
			end else begin
				sum_odd_n = fpcc_pkg::oc_add(sum_odd_q, word);
			end
		end else begin
			sum_even_n = fpcc_pkg::oc_add(sum_even_q, word);
		end
		count_n = (count_q == fpcc_pkg::COUNT_MAX) ? count_q : (count_q + 17'd1);
		odd_n = ~odd_q;
	end

	// Status decision on the last byte.
	always_comb begin
		total = {1'b0, count_n};
		lim_pay = LIM_HDR + {2'b00, len_n};
		lim_ck = lim_pay + 18'd2;
		sum_sel = odd_n ? sum_odd_n : sum_even_n;
		if (total < LIM_HDR) begin
			st = fpcc_pkg::ST_SHORT_HDR;
		end else if (total < lim_pay) begin
			st = fpcc_pkg::ST_SHORT_PAY;
		end else if (total < lim_ck) begin
			st = fpcc_pkg::ST_SHORT_CK;
		end else if (sum_sel != fpcc_pkg::SUM_GOOD) begin
			st = fpcc_pkg::ST_MISMATCH;
		end else begin
			st = fpcc_pkg::ST_OK;
		end
	end

	// Result items and their order.
	always_comb begin
		pay_res = '0;
		pay_res.kind = fpcc_pkg::KIND_PAYLOAD;
		pay_res.payload_byte = data_byte;
		pay_res.status = fpcc_pkg::ST_OK;
		pay_res.final_res = ~last;

		st_res = '0;
		st_res.kind = fpcc_pkg::KIND_STATUS;
		st_res.seq_number = seq_n;
		st_res.flag_bits = flags_n;
		st_res.payload_length = len_n;
		st_res.status = st;
		st_res.final_res = 1'b1;

		push = '0;
		if (take) begin
			if (is_payload) begin
				push.r0 = pay_res;
				push.r1 = st_res;
				push.cnt = last ? 2'd2 : 2'd1;
			end else begin
				push.r0 = st_res;
				push.cnt = last ? 2'd1 : 2'd0;
			end
		end
	end

	// Parser state; cleared after every status result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			odd_q <= 1'b0;
			seq_q <= '0;
			flags_q <= '0;
			len_q <= '0;
			sum_even_q <= '0;
			sum_odd_q <= '0;
			pend_q <= '0;
		end else if (take) begin
			if (last) begin
				count_q <= '0;
				odd_q <= 1'b0;
				seq_q <= '0;
				flags_q <= '0;
				len_q <= '0;
				sum_even_q <= '0;
				sum_odd_q <= '0;
				pend_q <= '0;
			end else begin
				count_q <= count_n;
				odd_q <= odd_n;
				seq_q <= seq_n;
				flags_q <= flags_n;
				len_q <= len_n;
				sum_even_q <= sum_even_n;
				sum_odd_q <= sum_odd_n;
				pend_q <= data_byte;
			end
		end
	end

endmodule

// ----- sv/fpcc_res_queue.sv -----
// Four-entry result queue that takes up to two results per cycle and gives one.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpcc_res_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fpcc_pkg::push_t push,
	input  logic            pop,
	output fpcc_pkg::res_t  head,
	output logic            not_empty,
	output logic            room2
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	fpcc_pkg::res_t mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  wptr_nx;

	assign wptr_nx = wptr_q + AW'(1);
	assign head = mem_q[rptr_q];
	assign not_empty = (count_q != '0);
	assign room2 = (count_q <= CW'(DEPTH - 2));

	// Entry storage; the second result lands one place after the first.
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if ((push.cnt != 2'd0) && (AW'(i) == wptr_q)) begin
				mem_q[i] <= push.r0;
			end else if ((push.cnt == 2'd2) && (AW'(i) == wptr_nx)) begin
				mem_q[i] <= push.r1;
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + AW'(push.cnt);
			rptr_q <= rptr_q + AW'(pop);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	`FPCC_ASSERT_ALWAYS(a_no_overflow, clk, arst_n, count_q <= CW'(DEPTH), "result queue over-full")
	`FPCC_ASSERT_IMPLY(a_push_room, clk, arst_n, push.cnt != 2'd0, room2, "push without room")
	`FPCC_ASSERT_IMPLY(a_pop_valid, clk, arst_n, pop, not_empty, "pop from empty queue")
	`FPCC_ASSERT_NEXT(a_drain, clk, arst_n, pop && (push.cnt == 2'd0), count_q == $past(count_q) - CW'(1), "fill count did not drop")

endmodule

// ----- sv/frame_parser_checksum_check.sv -----
// Datagram frame parser with 16-bit ones-complement checksum check. Bytes of a
// datagram come in one per request, the last one marked; the frame is a little-endian
// sequence number, a flags field of FLAG_BYTES bytes (the first byte is reported),
// a little-endian payload length, the payload and a checksum. Each payload byte is
// returned as a result as it arrives, and the last byte adds a status result
// (good, short header, short payload, short checksum or checksum mismatch) that ends
// the datagram and clears the parser. The block takes one byte per clock cycle while
// ready is high: each byte is parsed and summed in the cycle it is accepted and its
// results are written into a four-entry result queue, whose head drives the result
// channel. A last byte that falls inside the payload gives two results, so the input
// holds ready low for as long as the queue cannot take two more results; with the
// output side always ready the sustained rate is one byte per cycle.
`timescale 1ns / 1ps

module frame_parser_checksum_check #(
	parameter int FLAG_BYTES = fpcc_pkg::FLAG_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	fpcc_byte_if.sink     din,
	fpcc_res_if.source    dout
);

	logic            take;
	logic            pop;
	logic            room2;
	logic            not_empty;
	fpcc_pkg::push_t push;
	fpcc_pkg::res_t  head;

	// Request handshakes.
	assign din.ready = room2;
	assign take = din.valid & room2;
	assign pop = dout.ready & not_empty;

	fpcc_parser #(
		.FLAG_BYTES(FLAG_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (din.data_byte),
		.last      (din.last),
		.push      (push)
	);

	fpcc_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	// Result request fields from the queue head.
	assign dout.valid = not_empty;
	assign dout.kind = head.kind;
	assign dout.payload_byte = head.payload_byte;
	assign dout.seq_number = head.seq_number;
	assign dout.flag_bits = head.flag_bits;
	assign dout.payload_length = head.payload_length;
	assign dout.status = head.status;
	assign dout.final_res = head.final_res;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the frame parser with ones-complement checksum check.
`timescale 1ns / 1ps

module tb_top;

	localparam int FLAG_W = fpcc_pkg::FLAG_BYTES_DEF;
	localparam int HDR_LEN = 4 + FLAG_W;
	localparam int RANDOM_BYTES = 1450;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	fpcc_byte_if byte_ch();
	fpcc_res_if res_ch();

	frame_parser_checksum_check #(.FLAG_BYTES(FLAG_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(byte_ch),
		.dout(res_ch)
	);

	// Parser state as the block should hold it.
	logic [16:0] rx_count;
	logic        rx_odd;
	logic [15:0] seq_acc;
	logic [7:0]  flags_acc;
	logic [15:0] len_acc;
	logic [15:0] sum_even_start;
	logic [15:0] sum_odd_start;
	logic [7:0]  prev_byte;

	fpcc_pkg::res_t results_due[$];
	logic [7:0]     frame_q[$];

	int fail_count = 0;
	int bytes_sent = 0;
	int payload_seen = 0;
	int status_seen[5] = '{default: 0};
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int stall_left;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sixteen-bit add with the carry wrapped round to bit 0.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = a + b;
		return t[15:0] + t[16];
	endfunction

	function automatic void reset_parser();
		rx_count = '0;
		rx_odd = 1'b0;
		seq_acc = '0;
		flags_acc = '0;
		len_acc = '0;
		sum_even_start = '0;
		sum_odd_start = '0;
		prev_byte = '0;
	endfunction

	// Works out the results of one accepted byte and queues them.
	function automatic void parse_byte(input logic [7:0] b, input logic l);
		int p;
		fpcc_pkg::res_t r;
		logic [15:0] sum;
		fpcc_pkg::status_t st;
		p = int'(rx_count);
		if (p < 2) begin
			seq_acc = seq_acc | (16'(b) << (8 * p));
		end else if (p < 2 + FLAG_W) begin
			if (p == 2)
				flags_acc = b;
		end else if (p < HDR_LEN) begin
			len_acc = len_acc | (16'(b) << (8 * (p - 2 - FLAG_W)));
		end else if (p < HDR_LEN + int'(len_acc)) begin
			r = '0;
			r.kind = fpcc_pkg::KIND_PAYLOAD;
			r.payload_byte = b;
			r.final_res = !l;
			results_due.push_back(r);
		end

		// Both word alignments are summed, since the length is only known at the end.
		if (!rx_odd) begin
			if (p == 0)
				sum_odd_start = {8'h00, b};
			else
				sum_odd_start = ones_add(sum_odd_start, {b, prev_byte});
		end else begin
			sum_even_start = ones_add(sum_even_start, {b, prev_byte});
		end
		prev_byte = b;
		if (rx_count != fpcc_pkg::COUNT_MAX)
			rx_count++;
		rx_odd = !rx_odd;

		if (l) begin
			sum = rx_odd ? sum_odd_start : sum_even_start;
			if (int'(rx_count) < HDR_LEN)
				st = fpcc_pkg::ST_SHORT_HDR;
			else if (int'(rx_count) < HDR_LEN + int'(len_acc))
				st = fpcc_pkg::ST_SHORT_PAY;
			else if (int'(rx_count) < HDR_LEN + int'(len_acc) + 2)
				st = fpcc_pkg::ST_SHORT_CK;
			else if (sum != fpcc_pkg::SUM_GOOD)
				st = fpcc_pkg::ST_MISMATCH;
			else
				st = fpcc_pkg::ST_OK;
			r = '0;
			r.kind = fpcc_pkg::KIND_STATUS;
			r.seq_number = seq_acc;
			r.flag_bits = flags_acc;
			r.payload_length = len_acc;
			r.status = st;
			r.final_res = 1'b1;
			results_due.push_back(r);
			status_seen[int'(st)]++;
			reset_parser();
		end
	endfunction

	// Builds a well-formed datagram in frame_q with the checksum filled in.
	function automatic void build_frame(input logic [15:0] seq, input logic [7:0] flags,
		input logic [15:0] len, input int extras);
		int ck_pos;
		int start;
		logic [15:0] s;
		logic [15:0] word;
		frame_q.delete();
		frame_q.push_back(seq[7:0]);
		frame_q.push_back(seq[15:8]);
		frame_q.push_back(flags);
		for (int i = 1; i < FLAG_W; i++)
			frame_q.push_back(8'($urandom));
		frame_q.push_back(len[7:0]);
		frame_q.push_back(len[15:8]);
		for (int i = 0; i < int'(len); i++)
			frame_q.push_back(8'($urandom));
		ck_pos = frame_q.size();
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h00);
		for (int i = 0; i < extras; i++)
			frame_q.push_back(8'($urandom));

		// With an odd length the first byte stands alone and words start at byte 1.
		start = frame_q.size() % 2;
		s = start ? {8'h00, frame_q[0]} : 16'h0000;
		for (int i = start; i < frame_q.size(); i += 2)
			s = ones_add(s, {frame_q[i + 1], frame_q[i]});
		word = ~s;
		if ((ck_pos - start) % 2 == 0) begin
			frame_q[ck_pos] = word[7:0];
			frame_q[ck_pos + 1] = word[15:8];
		end else begin
			frame_q[ck_pos] = word[15:8];
			frame_q[ck_pos + 1] = word[7:0];
		end
	endfunction

	// Length of an idle stretch: mostly short, now and then long.
	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		else
			return $urandom_range(9, 40);
	endfunction

	// Offers one byte from a falling edge and returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = 0;
		if (tx_idle && $urandom_range(0, 99) < 45)
			gap = burst_len();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last <= l;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		parse_byte(b, l);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Result side: random stalls on ready while rx_idle is set.
	initial begin
		res_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (rx_idle && $urandom_range(0, 99) < 30) begin
				stall_left = burst_len() - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Compares every accepted result with the oldest one still due.
	always @(posedge clk) begin
		fpcc_pkg::res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: kind %0d, status %0d", res_ch.kind, res_ch.status);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (res_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
					fail_count++;
				end
				if (res_ch.payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %0h, got %0h",
						want.payload_byte, res_ch.payload_byte);
					fail_count++;
				end
				if (res_ch.seq_number !== want.seq_number) begin
					$error("seq_number: expected %0h, got %0h",
						want.seq_number, res_ch.seq_number);
					fail_count++;
				end
				if (res_ch.flag_bits !== want.flag_bits) begin
					$error("flag_bits: expected %0h, got %0h", want.flag_bits, res_ch.flag_bits);
					fail_count++;
				end
				if (res_ch.payload_length !== want.payload_length) begin
					$error("payload_length: expected %0h, got %0h",
						want.payload_length, res_ch.payload_length);
					fail_count++;
				end
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					fail_count++;
				end
				if (res_ch.final_res !== want.final_res) begin
					$error("final_res: expected %0d, got %0d", want.final_res, res_ch.final_res);
					fail_count++;
				end
				if (want.kind == fpcc_pkg::KIND_PAYLOAD)
					payload_seen++;
			end
		end
	end

	// Ends the run if no request moves on either side for too long.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Short datagrams for each outcome, the header extremes and trailing bytes.
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// A header cut after its first byte.
		frame_q = {8'hFF};
		send_frame();
		// All zero bytes: the sum is zero and counts as a mismatch.
		frame_q = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame();
		// Last byte inside the payload gives a payload result, then the status.
		build_frame(16'h1234, 8'hA5, 16'd2, 0);
		frame_q = frame_q[0:HDR_LEN];
		send_frame();
		// Only one checksum byte arrives.
		build_frame(16'h0001, 8'h80, 16'd0, 0);
		frame_q = frame_q[0:HDR_LEN];
		send_frame();
		// Good frame at the header extremes, with a byte after the checksum.
		build_frame(16'hFFFF, 8'hFF, 16'd1, 1);
		send_frame();
	endtask

	// Mostly good datagrams with random content; the rest corrupted, cut short or noise.
	task automatic test_random_frames();
		int base;
		int r;
		int cut;
		base = bytes_sent;
		while (bytes_sent < base + RANDOM_BYTES) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			r = $urandom_range(0, 99);
			if (r < 93) begin
				build_frame(16'($urandom), 8'($urandom),
					($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 48))
						: 16'($urandom_range(0, 12)),
					($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
				if (r >= 70 && r < 80) begin
					cut = $urandom_range(0, frame_q.size() - 1);
					frame_q[cut] = frame_q[cut] ^ (8'h01 << $urandom_range(0, 7));
				end else if (r >= 80) begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut)
						void'(frame_q.pop_back());
				end
			end else begin
				frame_q.delete();
				repeat ($urandom_range(1, 12))
					frame_q.push_back(8'($urandom));
			end
			send_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.last = 1'b0;
		reset_parser();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_frames();
		byte_ch.valid <= 1'b0;

		// Let the last results drain, then allow for anything left over.
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			fail_count++;
		end

		$display("Sent %0d bytes; datagrams ok %0d, short header %0d, short payload %0d,",
			bytes_sent, status_seen[fpcc_pkg::ST_OK], status_seen[fpcc_pkg::ST_SHORT_HDR],
			status_seen[fpcc_pkg::ST_SHORT_PAY]);
		$display("short checksum %0d, mismatch %0d; %0d payload bytes checked",
			status_seen[fpcc_pkg::ST_SHORT_CK], status_seen[fpcc_pkg::ST_MISMATCH],
			payload_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
